/* sv/fre_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the Fenwick range-sum engine.
// No dependencies; used by every module of the block except fre_fifo.
package fre_pkg;

  // field widths
  localparam int POS_W  = 11;
  localparam int PTR_W  = POS_W + 1;  // walk pointer, holds p + lowbit(p)
  localparam int DATA_W = 64;

  // default store depth and reset size
  localparam int              MAX_SIZE_DEF = 1024;
  localparam logic [POS_W-1:0] SIZE_RST    = 11'd1024;

  // command codes on in_cmd
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // classified operation kinds
  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_SET,
    KIND_QUERY
  } fre_kind_t;

  // one classified operation, front to back
  // ADD:   pos_a = position
  // SET:   pos_a = position, pos_b = position - 1
  // QUERY: pos_a = clamped last, pos_b = first - 1 (both zero for an empty range)
  typedef struct packed {
    fre_kind_t          kind;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [DATA_W-1:0]  value;
  } fre_op_t;

  // control from front to back
  typedef struct packed {
    logic [POS_W-1:0] eff_size;
    logic             clear_req;
  } fre_ctrl_t;

endpackage

/* sv/fre_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue, used between front and back and for finished results.
// Depends on nothing; the payload is a plain vector of DW bits.
module fre_fifo #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rd_data,
  output logic          empty
);

  logic [DW-1:0] ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;

  // occupancy count
  assign cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wr_data;
  end

  assign rd_data = ent_r[rp_r];
  assign full    = cnt_r[1];
  assign empty   = (cnt_r == 2'd0);

endmodule

/* sv/fre_front.sv */
`timescale 1ns / 1ps
// Front end: holds the size register, accepts items and classifies them.
// Depends on fre_pkg for command codes, operation and control structs.
module fre_front #(
  parameter int MAX_SIZE = fre_pkg::MAX_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_take,
  input  logic [1:0]                       in_cmd,
  input  logic [fre_pkg::POS_W-1:0]        in_first_pos,
  input  logic [fre_pkg::POS_W-1:0]        in_last_pos,
  input  logic signed [fre_pkg::DATA_W-1:0] in_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fre_pkg::POS_W-1:0]        cfg_active_size,
  output fre_pkg::fre_op_t                 op,
  output logic                             op_push,
  output fre_pkg::fre_ctrl_t               ctrl
);

  logic [fre_pkg::POS_W-1:0] size_r, size_nxt;
  logic [fre_pkg::POS_W-1:0] eff;
  logic [fre_pkg::POS_W-1:0] lo, hi;
  logic                      in_range;
  logic                      op_vld;

  assign cfg_ready = 1'b1;

  // size register
  assign size_nxt = (cfg_valid && cfg_ready) ? cfg_active_size : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= fre_pkg::SIZE_RST;
    end else begin
      size_r <= size_nxt;
    end
  end

  // effective size: capped by the store depth
  always_comb begin
    if (int'(size_r) < MAX_SIZE) begin
      eff = size_r;
    end else begin
      eff = fre_pkg::POS_W'(MAX_SIZE);
    end
  end

  assign ctrl.eff_size  = eff;
  assign ctrl.clear_req = cfg_valid && cfg_ready;

  // classify the item
  always_comb begin
    in_range = (in_first_pos != '0) && (in_first_pos <= eff);
    lo       = (in_first_pos == '0) ? fre_pkg::POS_W'(1) : in_first_pos;
    hi       = (in_last_pos > eff) ? eff : in_last_pos;
    op.kind  = fre_pkg::KIND_ADD;
    op.pos_a = in_first_pos;
    op.pos_b = '0;
    op.value = in_value;
    op_vld   = 1'b0;
    case (in_cmd)
      fre_pkg::CMD_ADD: begin
        op_vld = in_range;
      end
      fre_pkg::CMD_SET: begin
        op.kind  = fre_pkg::KIND_SET;
        op.pos_b = in_first_pos - fre_pkg::POS_W'(1);
        op_vld   = in_range;
      end
      fre_pkg::CMD_QUERY: begin
        op.kind = fre_pkg::KIND_QUERY;
        op_vld  = 1'b1;
        if (hi < lo) begin
          // empty range: both walks are empty, sum stays zero
          op.pos_a = '0;
        end else begin
          op.pos_a = hi;
          op.pos_b = lo - fre_pkg::POS_W'(1);
        end
      end
      default: begin
        op_vld = 1'b0;
      end
    endcase
  end

  assign op_push = in_take && op_vld;

endmodule

/* sv/fre_back.sv */
`timescale 1ns / 1ps
// Back end: node store and the sequencer for prefix walks, update walks
// and the clearing pass. Depends on fre_pkg for structs and widths.
module fre_back #(
  parameter int MAX_SIZE = fre_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fre_pkg::fre_ctrl_t          ctrl,
  input  fre_pkg::fre_op_t            op,
  input  logic                        op_avail,
  output logic                        op_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output logic [fre_pkg::DATA_W-1:0]  res_data,
  output logic                        clearing
);

  localparam int AW = $clog2(MAX_SIZE);
  localparam int PW = fre_pkg::PTR_W;
  localparam int DW = fre_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FIN,
    ST_UPD
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  fre_pkg::fre_kind_t         kind_r, kind_nxt;
  logic [fre_pkg::POS_W-1:0]  pos_a_r, pos_a_nxt;
  logic [fre_pkg::POS_W-1:0]  pos_b_r, pos_b_nxt;
  logic [PW-1:0]              ptr_r, ptr_nxt;
  logic [DW-1:0]              val_r, val_nxt;
  logic [DW-1:0]              acc_r, acc_nxt;
  logic [DW-1:0]              delta_r, delta_nxt;
  logic                       rd_pend_r, rd_pend_nxt;
  logic                       rd_neg_r, rd_neg_nxt;
  logic                       upd_pend_r, upd_pend_nxt;
  logic [AW-1:0]              wa_r, wa_nxt;
  logic [DW-1:0]              rdata_r;

  logic [PW-1:0]              lowbit;
  logic [PW-1:0]              ptr_dec;
  logic                       mem_re, mem_we;
  logic [AW-1:0]              mem_ra, mem_wa;
  logic [DW-1:0]              mem_wd;

  logic [DW-1:0]              mem [MAX_SIZE];

  assign lowbit  = ptr_r & (~ptr_r + PW'(1));
  assign ptr_dec = ptr_r - PW'(1);

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    kind_nxt     = kind_r;
    pos_a_nxt    = pos_a_r;
    pos_b_nxt    = pos_b_r;
    ptr_nxt      = ptr_r;
    val_nxt      = val_r;
    acc_nxt      = acc_r;
    delta_nxt    = delta_r;
    rd_pend_nxt  = 1'b0;
    rd_neg_nxt   = rd_neg_r;
    upd_pend_nxt = 1'b0;
    wa_nxt       = wa_r;
    op_pop       = 1'b0;
    res_push     = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = AW'(ptr_dec);
    mem_we       = 1'b0;
    mem_wa       = wa_r;
    mem_wd       = rdata_r + delta_r;

    // node read last cycle lands in the running sum
    if (rd_pend_r) begin
      acc_nxt = rd_neg_r ? (acc_r - rdata_r) : (acc_r + rdata_r);
    end
    // node read last cycle gets the delta written back
    if (upd_pend_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_avail) begin
          op_pop    = 1'b1;
          kind_nxt  = op.kind;
          pos_a_nxt = op.pos_a;
          pos_b_nxt = op.pos_b;
          val_nxt   = op.value;
          delta_nxt = op.value;
          ptr_nxt   = PW'(op.pos_a);
          acc_nxt   = '0;
          state_nxt = (op.kind == fre_pkg::KIND_ADD) ? ST_UPD : ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        // prefix up to pos_a, added
        if (ptr_r != '0) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_neg_nxt  = 1'b0;
          ptr_nxt     = ptr_r - lowbit;
        end else begin
          ptr_nxt   = PW'(pos_b_r);
          state_nxt = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        // prefix up to pos_b, subtracted
        if (ptr_r != '0) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_neg_nxt  = 1'b1;
          ptr_nxt     = ptr_r - lowbit;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (kind_r == fre_pkg::KIND_QUERY) begin
          if (!res_full) begin
            res_push  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          // set: add the difference to the current point value
          delta_nxt = val_r - acc_r;
          ptr_nxt   = PW'(pos_a_r);
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // read-modify-write up the tree, one node a cycle
        if ((ptr_r != '0) && (ptr_r <= PW'(ctrl.eff_size))) begin
          mem_re       = 1'b1;
          upd_pend_nxt = 1'b1;
          wa_nxt       = AW'(ptr_dec);
          ptr_nxt      = ptr_r + lowbit;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // size write restarts the clearing pass
    if (ctrl.clear_req) begin
      state_nxt    = ST_CLEAR;
      clr_nxt      = '0;
      rd_pend_nxt  = 1'b0;
      upd_pend_nxt = 1'b0;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      rd_pend_r  <= 1'b0;
      upd_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      rd_pend_r  <= rd_pend_nxt;
      upd_pend_r <= upd_pend_nxt;
    end
    kind_r   <= kind_nxt;
    pos_a_r  <= pos_a_nxt;
    pos_b_r  <= pos_b_nxt;
    ptr_r    <= ptr_nxt;
    val_r    <= val_nxt;
    acc_r    <= acc_nxt;
    delta_r  <= delta_nxt;
    rd_neg_r <= rd_neg_nxt;
    wa_r     <= wa_nxt;
  end

  // node store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  assign res_data = acc_r;
  assign clearing = (state_r == ST_CLEAR);

  // checks
  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear_req |=> state_r == ST_CLEAR)
    else $error("size write did not start clearing pass");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> int'(mem_wa) < MAX_SIZE)
    else $error("node write beyond store depth");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && !ctrl.clear_req) |=> (state_r == ST_WALK_A || state_r == ST_UPD))
    else $error("popped item did not start a walk");

endmodule

/* sv/fenwick_range_sum_engine.sv */
`timescale 1ns / 1ps
// Top level of the Fenwick range-sum engine: front, op queue, back, result queue.
// Depends on fre_pkg, fre_front, fre_fifo and fre_back.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------
//  input   | in_cmd, in_first_pos, in_last_pos, in_value   | in_push / in_full
//  result  | out_range_sum                                 | out_pop / out_empty
//  config  | cfg_active_size                               | cfg_valid / cfg_ready
//
// An add walks up to log2(MAX_SIZE)+1 nodes, one per cycle on the single store
// port. A query runs two prefix walks. A set runs both prefix walks then the
// update walk. After reset and after every cfg write a clearing pass runs;
// in_full stays high during it. Two op slots and two result slots decouple stalls.
module fenwick_range_sum_engine #(
  parameter int MAX_SIZE = fre_pkg::MAX_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_cmd,
  input  logic [fre_pkg::POS_W-1:0]         in_first_pos,
  input  logic [fre_pkg::POS_W-1:0]         in_last_pos,
  input  logic signed [fre_pkg::DATA_W-1:0] in_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [fre_pkg::DATA_W-1:0] out_range_sum,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fre_pkg::POS_W-1:0]         cfg_active_size
);

  localparam int OP_W = $bits(fre_pkg::fre_op_t);

  fre_pkg::fre_op_t             op_in, op_head;
  fre_pkg::fre_ctrl_t           ctrl;
  logic                         op_push, op_pop, op_full, op_empty;
  logic [OP_W-1:0]              op_rd;
  logic                         res_push, res_full;
  logic [fre_pkg::DATA_W-1:0]   res_data, res_rd;
  logic                         clearing;
  logic                         in_take, out_take;

  // item handshakes
  assign in_full  = op_full || clearing;
  assign in_take  = in_push && !in_full;
  assign out_take = out_pop && !out_empty;

  fre_front #(
    .MAX_SIZE(MAX_SIZE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (in_take),
    .in_cmd          (in_cmd),
    .in_first_pos    (in_first_pos),
    .in_last_pos     (in_last_pos),
    .in_value        (in_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_size (cfg_active_size),
    .op              (op_in),
    .op_push         (op_push),
    .ctrl            (ctrl)
  );

  // op queue between front and back
  fre_fifo #(
    .DW(OP_W)
  ) u_op_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .wr_data (op_in),
    .full    (op_full),
    .pop     (op_pop),
    .rd_data (op_rd),
    .empty   (op_empty)
  );

  assign op_head = fre_pkg::fre_op_t'(op_rd);

  fre_back #(
    .MAX_SIZE(MAX_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .op       (op_head),
    .op_avail (!op_empty),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data),
    .clearing (clearing)
  );

  // result queue
  fre_fifo #(
    .DW(fre_pkg::DATA_W)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_take),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

  assign out_range_sum = res_rd;

endmodule

/* tb/tb_fenwick_range_sum_engine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fenwick_range_sum_engine: directed table, then random phases
// over several active sizes. Depends on fre_pkg and the engine RTL only.
module tb_fenwick_range_sum_engine;

  localparam int          POS_W       = fre_pkg::POS_W;
  localparam int          DATA_W      = fre_pkg::DATA_W;
  localparam logic [1:0]  CMD_ADD     = fre_pkg::CMD_ADD;
  localparam logic [1:0]  CMD_SET     = fre_pkg::CMD_SET;
  localparam logic [1:0]  CMD_QUERY   = fre_pkg::CMD_QUERY;
  localparam logic [POS_W-1:0] SIZE_RST = fre_pkg::SIZE_RST;
  localparam int          PERIOD      = 10;
  localparam int          MAX_POS     = fre_pkg::MAX_SIZE_DEF;
  localparam int          SETTLE      = 160;    // longest op chain still in flight after drain
  localparam int          HOLD_CYCLES = 400;    // one long receiver hold-off
  localparam int          IDLE_LIMIT  = 10000;  // cycles with no handshake at all
  localparam logic [1:0]  CMD_NONE    = 2'd3;   // unused command code
  localparam logic [63:0] MOST_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
    logic [DATA_W-1:0] value;
  } op_item_t;

  typedef struct {
    op_item_t          op;
    bit                fixed;   // expected sum typed in the table
    logic [DATA_W-1:0] fixed_sum;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [1:0]               in_cmd = CMD_ADD;
  logic [POS_W-1:0]         in_first_pos = '0;
  logic [POS_W-1:0]         in_last_pos = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic signed [DATA_W-1:0] out_range_sum;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [POS_W-1:0]         cfg_active_size = SIZE_RST;

  // predictor state: point values and the size register
  logic [DATA_W-1:0] point_val [1:MAX_POS];
  int unsigned       size_reg;
  logic [DATA_W-1:0] sum_due [$];   // range sums still to come, oldest first
  dir_row_t          dir_rows [$];

  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;
  int unsigned rx_stall = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  fenwick_range_sum_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_first_pos    (in_first_pos),
    .in_last_pos     (in_last_pos),
    .in_value        (in_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_range_sum   (out_range_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_size (cfg_active_size)
  );

  always #(PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_size();
    return (size_reg > MAX_POS) ? MAX_POS : size_reg;
  endfunction

  function automatic void clear_points();
    for (int p = 1; p <= MAX_POS; p++) point_val[p] = '0;
  endfunction

  // apply one accepted item; returns 1 when it yields a range sum
  function automatic bit predict_item(input op_item_t op, output logic [DATA_W-1:0] acc);
    int unsigned n, pos, lo, hi;
    n   = eff_size();
    pos = op.first_pos;
    acc = '0;
    case (op.cmd)
      CMD_ADD: if (pos >= 1 && pos <= n) point_val[pos] = point_val[pos] + op.value;
      CMD_SET: if (pos >= 1 && pos <= n) point_val[pos] = op.value;
      CMD_QUERY: begin
        lo = (pos == 0) ? 1 : pos;
        hi = (op.last_pos > n) ? n : op.last_pos;
        for (int p = lo; p <= hi; p++) acc = acc + point_val[p];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [DATA_W-1:0] random_value();
    longint small_v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        small_v = longint'($urandom_range(0, 200)) - 100;
        return small_v;
      end
      8:       return ($urandom_range(0, 2) == 0) ? MOST_POS :
                      ($urandom_range(0, 1) == 0) ? MOST_NEG : ALL_ONES;
      9:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // in-range position, biased toward low positions and the top one
  function automatic int unsigned pick_pos(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(1, (n < 16) ? n : 16);
    if (r == 3) return n;
    return $urandom_range(1, n);
  endfunction

  function automatic op_item_t random_item();
    op_item_t    op;
    int unsigned n, r;
    n = eff_size();
    r = $urandom_range(0, 99);
    op.cmd = (r < 35) ? CMD_ADD : (r < 58) ? CMD_SET : (r < 96) ? CMD_QUERY : CMD_NONE;
    op.value = random_value();
    op.first_pos = POS_W'($urandom_range(0, 2047));
    op.last_pos = POS_W'($urandom_range(0, 2047));
    if (op.cmd == CMD_QUERY) begin
      r = $urandom_range(0, 9);
      if (n != 0 && r < 8) begin
        op.first_pos = POS_W'(pick_pos(n));
        op.last_pos = (r == 7) ? POS_W'($urandom_range(n, 2047)) :
                                 POS_W'($urandom_range(op.first_pos, n));
      end
    end else if (n != 0 && $urandom_range(0, 9) != 0) begin
      op.first_pos = POS_W'(pick_pos(n));
      // rewrite a point with its current value now and then
      if (op.cmd == CMD_SET && $urandom_range(0, 9) == 0) op.value = point_val[op.first_pos];
    end
    return op;
  endfunction

  function automatic int unsigned pick_tx_gap();
    int unsigned r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    if (r < 98) return $urandom_range(20, 60);
    tx_burst = $urandom_range(30, 80);
    return 0;
  endfunction

  function automatic logic next_pop();
    int unsigned r;
    if (rx_burst > 0) begin
      rx_burst--;
      return 1'b1;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 1'b1;
    if (r < 88) begin
      rx_stall = $urandom_range(0, 2);
      return 1'b0;
    end
    if (r < 94) begin
      rx_stall = $urandom_range(10, 60);
      return 1'b0;
    end
    rx_burst = $urandom_range(30, 100);
    return 1'b1;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int unsigned lo_pos, hi_pos,
                         input logic [DATA_W-1:0] value, input bit fixed,
                         input logic [DATA_W-1:0] fixed_sum);
    dir_row_t row;
    row.op.cmd       = cmd;
    row.op.first_pos = POS_W'(lo_pos);
    row.op.last_pos  = POS_W'(hi_pos);
    row.op.value     = value;
    row.fixed        = fixed;
    row.fixed_sum    = fixed_sum;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // offer one item until accepted, then log its expected sum
  task automatic offer(input op_item_t op, input bit fixed, input logic [DATA_W-1:0] fixed_sum);
    logic [DATA_W-1:0] acc;
    int unsigned       gap;
    in_push      <= 1'b1;
    in_cmd       <= op.cmd;
    in_first_pos <= op.first_pos;
    in_last_pos  <= op.last_pos;
    in_value     <= op.value;
    do @(posedge clk); while (in_full);
    if (predict_item(op, acc)) sum_due.insert(sum_due.size(), fixed ? fixed_sum : acc);
    gap = pick_tx_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (sum_due.size() != 0);
  endtask

  // size write only once the engine has gone quiet
  task automatic write_size(input logic [POS_W-1:0] new_size);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_active_size <= new_size;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = new_size;
    clear_points();
  endtask

  // ---------------------------------------------------------------- result side

  task automatic check_sum(input logic [DATA_W-1:0] got);
    logic [DATA_W-1:0] want;
    if (sum_due.size() == 0) begin
      $error("range_sum: no result expected, got %0d", $signed(got));
      n_fail++;
    end else begin
      want = sum_due.pop_front();
      if (got !== want) begin
        $error("range_sum: expected %0d, got %0d", $signed(want), $signed(got));
        n_fail++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) check_sum(out_range_sum);
      if (hold_req && !hold_done) begin
        // long hold-off so the op and result queues back up
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= next_pop();
      end
    end
  end

  // watchdog: no handshake of any kind for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int unsigned phase_size [7];
    int unsigned phase_items [7];
    int unsigned done;
    bit          paused;
    op_item_t    op;

    phase_size  = '{1, 0, 2047, 8, 1023, 33, 1024};
    phase_items = '{100, 40, 300, 200, 300, 160, 300};
    size_reg = SIZE_RST;
    clear_points();

    // directed table at reset size
    add_row(CMD_QUERY, 1, 1024, '0, 1'b1, '0);           // empty store
    add_row(CMD_QUERY, 0, 0, '0, 1'b1, '0);              // first 0 acts as 1, range empty
    add_row(CMD_ADD, 1, 0, MOST_POS, 1'b0, '0);
    add_row(CMD_ADD, 1024, 0, MOST_NEG, 1'b0, '0);
    add_row(CMD_QUERY, 1, 1024, '0, 1'b1, ALL_ONES);
    add_row(CMD_ADD, 0, 0, 64'd5, 1'b0, '0);             // update at position 0 ignored
    add_row(CMD_ADD, 1025, 0, 64'd5, 1'b0, '0);          // just above size, ignored
    add_row(CMD_SET, 2047, 2047, 64'd9, 1'b0, '0);       // far above size, ignored
    add_row(CMD_QUERY, 0, 2047, '0, 1'b1, ALL_ONES);     // last clamped to size
    add_row(CMD_SET, 1, 0, 64'd7, 1'b0, '0);
    add_row(CMD_QUERY, 1, 1, '0, 1'b1, 64'd7);
    add_row(CMD_ADD, 1024, 0, ALL_ONES, 1'b0, '0);       // wraps to most positive
    add_row(CMD_QUERY, 1024, 2047, '0, 1'b1, MOST_POS);
    add_row(CMD_SET, 1024, 0, MOST_POS, 1'b0, '0);       // same value, zero difference
    add_row(CMD_SET, 512, 0, ALL_ONES, 1'b0, '0);
    add_row(CMD_NONE, 1, 1024, 64'd1, 1'b0, '0);         // unused command
    add_row(CMD_QUERY, 1, 1024, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1025, 2047, '0, 1'b1, '0);        // first above size
    add_row(CMD_QUERY, 600, 500, '0, 1'b1, '0);          // last below first
    add_row(CMD_QUERY, 512, 512, '0, 1'b1, ALL_ONES);
    add_row(CMD_ADD, 1023, 0, 64'h5555_AAAA_5555_AAAA, 1'b0, '0);
    add_row(CMD_QUERY, 1000, 1023, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1, 1023, '0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].fixed_sum);

    // random phases, one per active size
    paused = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      write_size(POS_W'(phase_size[ph]));
      done = 0;
      while (done < phase_items[ph]) begin
        op = random_item();
        done++;
        if (ph == 3 && done == 100 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
        if (ph == 4 && done == 40) hold_req = 1'b1;
        offer(op, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (n_fail == 0 && sum_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
